// File: rtl/core/int64_divide_remainder_defines.svh
// Assertion macros used by the divider controller RTL.
`ifndef INT64_DIVIDE_REMAINDER_DEFINES_SVH
`define INT64_DIVIDE_REMAINDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/idr_pkg.sv
// Package: shared widths and the controller-to-datapath command type.
package idr_pkg;

  // Width of each operand and result field on the ports.
  localparam int unsigned FIELD_W = 64;
  // Packed stream data width: two fields side by side.
  localparam int unsigned TDATA_W = 2 * FIELD_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands, take magnitudes
    logic step;    // one shift-and-subtract iteration
    logic finish;  // fix signs, write output register
  } idr_cmd_t;

endpackage

// File: rtl/core/int64_divide_remainder.sv
// Top level: stream wrapper joining the divider controller and datapath.
//
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tdata {divisor, dividend}, tuser signed_mode
// out_     master     out_tvalid/out_tready  tdata {remainder, quotient}, tuser divide_by_zero
//
// Each request runs as a load step that captures operands and forms magnitudes, one
// iteration per quotient bit through the single shared DATA_WIDTH+1 bit subtractor,
// and a sign fix-up step that writes the output register.
// A new request is accepted in the cycle after fix-up, even while the last result waits.
// Reset (rst_n low, synchronous) clears the controller and drops any pending result.
// A stalled output holds the fix-up stage until the output register frees.
module int64_divide_remainder #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [63:0] dividend, [127:64] divisor
  input  logic [idr_pkg::TDATA_W-1:0]  in_tdata,
  // [0] signed_mode
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [63:0] quotient, [127:64] remainder
  output logic [idr_pkg::TDATA_W-1:0]  out_tdata,
  // [0] divide_by_zero
  output logic                         out_tuser
);

  idr_pkg::idr_cmd_t            cmd;
  logic [idr_pkg::FIELD_W-1:0]  quotient;
  logic [idr_pkg::FIELD_W-1:0]  remainder;

  // Sequence load, iterations and fix-up; own both handshakes.
  idr_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Operand magnitudes, restoring iterations, signs and the held result.
  idr_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .dividend       (in_tdata[idr_pkg::FIELD_W-1:0]),
    .divisor        (in_tdata[idr_pkg::TDATA_W-1:idr_pkg::FIELD_W]),
    .signed_mode    (in_tuser),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (out_tuser)
  );

  assign out_tdata = {remainder, quotient};

endmodule

// File: rtl/core/idr_dp.sv
// Datapath: operand registers, shared restoring subtractor, sign fix-up, output register.
module idr_dp #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                         clk,
  input  idr_pkg::idr_cmd_t            cmd,
  input  logic [idr_pkg::FIELD_W-1:0]  dividend,
  input  logic [idr_pkg::FIELD_W-1:0]  divisor,
  input  logic                         signed_mode,
  output logic [idr_pkg::FIELD_W-1:0]  quotient,
  output logic [idr_pkg::FIELD_W-1:0]  remainder,
  output logic                         divide_by_zero
);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_rem_r, neg_rem_nxt;
  logic                  dbz_r, dbz_nxt;
  logic [idr_pkg::FIELD_W-1:0] out_q_r, out_q_nxt;
  logic [idr_pkg::FIELD_W-1:0] out_rem_r, out_rem_nxt;
  logic                        out_dbz_r, out_dbz_nxt;

  logic [DATA_WIDTH-1:0] n_w, d_w;
  logic                  n_neg, d_neg;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] q_fix, rem_fix;

  always_comb begin
    n_w   = dividend[DATA_WIDTH-1:0];
    d_w   = divisor[DATA_WIDTH-1:0];
    n_neg = signed_mode & n_w[DATA_WIDTH-1];
    d_neg = signed_mode & d_w[DATA_WIDTH-1];

    // Partial remainder shifted left with the next dividend bit, minus divisor.
    trial = {rem_r, quo_r[DATA_WIDTH-1]} - {1'b0, dvs_r};

    q_fix   = neg_q_r ? (~quo_r + 1'b1) : quo_r;
    rem_fix = neg_rem_r ? (~rem_r + 1'b1) : rem_r;

    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dvs_nxt     = dvs_r;
    neg_q_nxt   = neg_q_r;
    neg_rem_nxt = neg_rem_r;
    dbz_nxt     = dbz_r;
    out_q_nxt   = out_q_r;
    out_rem_nxt = out_rem_r;
    out_dbz_nxt = out_dbz_r;

    if (cmd.load) begin
      rem_nxt     = '0;
      quo_nxt     = n_neg ? (~n_w + 1'b1) : n_w;
      dvs_nxt     = d_neg ? (~d_w + 1'b1) : d_w;
      neg_q_nxt   = n_neg ^ d_neg;
      neg_rem_nxt = n_neg;
      dbz_nxt     = (d_w == '0);
    end

    if (cmd.step) begin
      // No borrow: divisor fits, take the difference and set the quotient bit.
      if (!trial[DATA_WIDTH]) begin
        rem_nxt = trial[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]};
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.finish) begin
      out_dbz_nxt = dbz_r;
      if (dbz_r) begin
        out_q_nxt   = '0;
        out_rem_nxt = '0;
      end else begin
        out_q_nxt   = idr_pkg::FIELD_W'(q_fix);
        out_rem_nxt = idr_pkg::FIELD_W'(rem_fix);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_rem_r <= neg_rem_nxt;
    dbz_r     <= dbz_nxt;
    out_q_r   <= out_q_nxt;
    out_rem_r <= out_rem_nxt;
    out_dbz_r <= out_dbz_nxt;
  end

  assign quotient       = out_q_r;
  assign remainder      = out_rem_r;
  assign divide_by_zero = out_dbz_r;

endmodule

// File: rtl/core/idr_ctrl.sv
// Controller: sequencing state machine, iteration counter and output valid.
`include "int64_divide_remainder_defines.svh"

module idr_ctrl #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output idr_pkg::idr_cmd_t cmd
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             slot_free;
  logic             in_fire;
  logic             run_active;
  logic             cnt_zero;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign run_active = (state_r == ST_RUN);
  assign cnt_zero   = (cnt_r == '0);

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_tvalid;
    cmd.step   = run_active;
    cmd.finish = (state_r == ST_FIX) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a finish refills it this cycle.
      if (out_valid_r && out_tready && !cmd.finish) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cnt_r   <= LAST_STEP;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_zero) begin
            state_r <= ST_FIX;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_FIX: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `IDR_ASSERT_NEXT(a_start_run, in_fire, run_active && (cnt_r == LAST_STEP), "run not started")
  `IDR_ASSERT_NEXT(a_count, run_active && !cnt_zero, cnt_r == $past(cnt_r) - 1'b1, "bad count")
  `IDR_ASSERT_NEXT(a_last_step, run_active && cnt_zero, state_r == ST_FIX, "fix-up skipped")
  `IDR_ASSERT_NOW(a_no_overwrite, cmd.finish, !out_tvalid || out_tready, "result overwritten")

endmodule
